### design/rnlu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnlu_pkg
// Types, codes and the sigmoid sample table of the rate neuron update block.
// ----------------------------------------------------------------------------
package rnlu_pkg;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_COMMIT = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [1:0] REG_GAIN         = 2'd1;
	localparam logic [1:0] REG_STEP_RATIO   = 2'd2;
	localparam logic [1:0] REG_HISTORY_USED = 2'd3;

	localparam int ADDR_MAX_W    = 18;
	localparam int TABLE_ENTRIES = 256;
	localparam int TABLE_LAST    = TABLE_ENTRIES - 1;
	localparam int TIW           = $clog2(TABLE_ENTRIES);
	localparam int SPAN_Q16      = 262144;
	localparam int ONE_Q15       = 32768;
	localparam longint unsigned INV_E_Q32 = 64'd1580030169;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         neuron;
		logic signed [31:0] activation;
		logic [2:0]         delay;
	} in_item_t;

	typedef struct packed {
		logic [15:0] rate;
		logic [7:0]  neuron_out;
	} out_item_t;

	typedef struct packed {
		logic                  is_read;
		logic [7:0]            neuron;
		logic signed [31:0]    activation;
		logic [ADDR_MAX_W-1:0] rd_addr;
		logic [ADDR_MAX_W-1:0] wr_addr;
	} job_t;

	typedef logic [15:0] sig_table_t [TABLE_ENTRIES];

	// shift and subtract, used only while the table is built
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] sig_sample(input int k);
		longint unsigned last;
		longint unsigned mag;
		longint unsigned z;
		longint unsigned ip;
		longint unsigned f;
		longint unsigned term;
		longint unsigned e;
		longint unsigned den;
		longint unsigned s;
		longint          num;
		longint          sum;
		last = longint'(TABLE_LAST);
		num  = 8 * longint'(k) - 4 * longint'(last);
		mag  = (num < 0) ? longint'(-num) : longint'(num);
		z    = udiv(mag << 33, last);
		ip   = z >> 32;
		f    = z & 64'hFFFF_FFFF;
		term = 64'd1 << 32;
		sum  = longint'(term);
		for (int n = 1; n <= 16; n++) begin
			term = udiv((term * f) >> 32, longint'(n));
			if ((n % 2) == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		e = (sum < 0) ? 64'd0 : longint'(sum);
		for (int n = 0; n < 16; n++) begin
			if (longint'(n) < ip) e = (e * INV_E_Q32) >> 32;
		end
		den = (64'd1 << 32) + e;
		s   = udiv((64'd1 << 47) + (den >> 1), den);
		if (num < 0) s = 64'd32768 - s;
		return s[15:0];
	endfunction

	function automatic sig_table_t build_table();
		sig_table_t t;
		for (int k = 0; k < TABLE_ENTRIES; k++) t[k] = sig_sample(k);
		return t;
	endfunction

	localparam sig_table_t SIG_TABLE = build_table();

endpackage
`default_nettype wire

### design/rnlu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnlu_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rnlu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/rnlu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnlu_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rnlu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rnlu_pkg::job_t push_job,
	input  wire logic          pop,
	output rnlu_pkg::job_t     head,
	output logic               empty,
	output logic               full
);
	import rnlu_pkg::*;

	job_t       slot_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

### design/rnlu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnlu_front
// Accepts items, keeps the ring index, forms history addresses, queues jobs.
// ----------------------------------------------------------------------------
module rnlu_front #(
	parameter int NEURONS       = 256,
	parameter int HISTORY_DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rnlu_pkg::in_item_t item,
	input  wire logic [3:0]        history_used,
	input  wire logic              q_full,
	input  wire logic              clearing,
	output logic                   busy,
	output logic                   push,
	output rnlu_pkg::job_t         push_job
);
	import rnlu_pkg::*;

	localparam int CW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	logic [CW-1:0] idx_q;
	logic [7:0]    used;
	logic [7:0]    cur;
	logic [7:0]    dm;
	logic [7:0]    rcol;
	logic [7:0]    wcol;
	logic          accept;
	logic          in_range;

	always_comb begin
		if (history_used == 4'd0) used = 8'd1;
		else if (32'(history_used) > HISTORY_DEPTH) used = 8'(HISTORY_DEPTH);
		else used = 8'(history_used);
	end

	always_comb begin
		cur = 8'(idx_q);
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			if (cur >= used) cur = cur - used;
		end
		dm  = 8'(item.delay);
		for (int k = 0; k < 7; k++) begin
			if (dm >= used) dm = dm - used;
		end
		rcol = (cur >= dm) ? cur - dm : cur + used - dm;
		wcol = (cur + 8'd1 == used) ? 8'd0 : cur + 8'd1;
	end

	assign busy     = q_full | clearing;
	assign accept   = start & ~busy;
	assign in_range = 32'(item.neuron) < NEURONS;
	assign push     = accept & in_range
		& ((item.opcode == OP_UPDATE) || (item.opcode == OP_READ));

	always_comb begin
		push_job.is_read    = (item.opcode == OP_READ);
		push_job.neuron     = item.neuron;
		push_job.activation = item.activation;
		push_job.rd_addr    = ADDR_MAX_W'(item.neuron) * ADDR_MAX_W'(HISTORY_DEPTH)
			+ ADDR_MAX_W'((item.opcode == OP_READ) ? rcol : cur);
		push_job.wr_addr    = ADDR_MAX_W'(item.neuron) * ADDR_MAX_W'(HISTORY_DEPTH)
			+ ADDR_MAX_W'(wcol);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept && item.opcode == OP_COMMIT) begin
			idx_q <= CW'(wcol);
		end
	end
endmodule
`default_nettype wire

### design/rnlu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rnlu_back
// Clears the rate history, then runs queued jobs: delayed reads and the
// gain, sigmoid interpolation and leaky integration of updates.
// ----------------------------------------------------------------------------
module rnlu_back #(
	parameter int NEURONS       = 256,
	parameter int HISTORY_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rnlu_pkg::job_t     head,
	input  wire logic               empty,
	output logic                    pop,
	input  wire logic signed [31:0] threshold,
	input  wire logic [20:0]        gain,
	input  wire logic [15:0]        step_ratio,
	output logic                    clearing,
	output logic                    done,
	output rnlu_pkg::out_item_t     result
);
	import rnlu_pkg::*;

	localparam int DEPTH = NEURONS * HISTORY_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = 20 + TIW;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RDOUT = 4'd2;
	localparam logic [3:0] ST_Y     = 4'd3;
	localparam logic [3:0] ST_P     = 4'd4;
	localparam logic [3:0] ST_S     = 4'd5;
	localparam logic [3:0] ST_S2    = 4'd6;
	localparam logic [3:0] ST_N     = 4'd7;
	localparam logic [3:0] ST_W     = 4'd8;

	logic [3:0]          state_q;
	logic [AW-1:0]       clr_q;
	job_t                job_q;
	logic [37:0]         pl_q;
	logic signed [37:0]  ph_q;
	logic [15:0]         r_q;
	logic signed [19:0]  y_q;
	logic [PW-1:0]       p_q;
	logic [15:0]         t0_q;
	logic signed [36:0]  pf_q;
	logic signed [17:0]  s_q;
	logic signed [34:0]  m_q;
	logic                done_q;
	out_item_t           result_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [15:0]         wdata;
	logic [15:0]         rdata;
	logic signed [32:0]  diff;
	logic signed [55:0]  prod;
	logic signed [55:0]  ysh;
	logic [19:0]         ypos;
	logic [TIW-1:0]      ti;
	logic [TIW-1:0]      ti1;
	logic [18:0]         tf;
	logic signed [16:0]  dt;
	logic signed [36:0]  pfr;
	logic signed [36:0]  sadd;
	logic signed [34:0]  nrt;
	logic [15:0]         nr;

	rnlu_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (AW'(head.rd_addr)),
		.rdata (rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign done     = done_q;
	assign result   = result_q;

	assign diff = {head.activation[31], head.activation} - {threshold[31], threshold};
	assign prod = (56'(ph_q) <<< 17) + $signed({18'b0, pl_q});
	assign ysh  = prod >>> 16;
	assign ypos = 20'(y_q + 20'sd262144);
	assign ti   = p_q[19 +: TIW];
	assign tf   = p_q[18:0];
	assign ti1  = (32'(ti) == TABLE_LAST) ? ti : ti + TIW'(1);
	assign dt   = $signed({1'b0, SIG_TABLE[ti1]}) - $signed({1'b0, SIG_TABLE[ti]});
	assign pfr  = (pf_q + 37'sd262144) >>> 19;
	assign sadd = $signed({21'b0, t0_q}) + pfr;
	assign nrt  = $signed({19'b0, r_q}) + ((m_q + 35'sd32768) >>> 16);

	always_comb begin
		if (nrt < 35'sd0) nr = 16'd0;
		else if (nrt > 35'sd32768) nr = 16'(ONE_Q15);
		else nr = nrt[15:0];
	end

	always_comb begin
		we    = 1'b0;
		waddr = AW'(job_q.wr_addr);
		wdata = nr;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 16'd0;
		end else if (state_q == ST_W) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= head;
				pl_q  <= 38'(gain) * 38'(diff[16:0]);
				ph_q  <= $signed({1'b0, gain}) * $signed(diff[32:17]);
			end
			ST_Y: begin
				r_q <= rdata;
				if (ysh < -56'sd262144) y_q <= -20'sd262144;
				else if (ysh > 56'sd262144) y_q <= 20'sd262144;
				else y_q <= 20'(ysh);
			end
			ST_P: p_q <= PW'(ypos) * PW'(TABLE_LAST);
			ST_S: begin
				t0_q <= SIG_TABLE[ti];
				pf_q <= dt * $signed({1'b0, tf});
			end
			ST_S2: s_q <= 18'(sadd);
			ST_N: m_q <= $signed({1'b0, step_ratio}) * (s_q - $signed({2'b0, r_q}));
			default: begin
			end
		endcase
		if (state_q == ST_RDOUT) begin
			result_q.rate       <= rdata;
			result_q.neuron_out <= job_q.neuron;
		end else if (state_q == ST_W) begin
			result_q.rate       <= nr;
			result_q.neuron_out <= job_q.neuron;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RDOUT) || (state_q == ST_W);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: if (!empty) state_q <= head.is_read ? ST_RDOUT : ST_Y;
				ST_RDOUT: state_q <= ST_IDLE;
				ST_Y:     state_q <= ST_P;
				ST_P:     state_q <= ST_S;
				ST_S:     state_q <= ST_S2;
				ST_S2:    state_q <= ST_N;
				ST_N:     state_q <= ST_W;
				ST_W:     state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/rate_neuron_leaky_update_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_neuron_leaky_update_top
// Leaky-integrator rate neuron population with a ring of past rates.
// ----------------------------------------------------------------------------
// After reset the block holds busy while it zeroes the rate history, one
// entry a cycle. A read or an update gives one result; a commit gives none.
// The back sequencer works on one item at a time: a read passes through the
// idle and read-out states, an update through the idle, Y, P, S, S2, N and
// W states. A two-entry queue in front of it lets start be taken until the
// queue fills. Results appear for one cycle on done and cannot be held off.
module rate_neuron_leaky_update_top #(
	parameter int NEURONS       = 256,
	parameter int HISTORY_DEPTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire rnlu_pkg::in_item_t item,
	output logic                    done,
	output rnlu_pkg::out_item_t     result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import rnlu_pkg::*;

	logic signed [31:0] threshold_q;
	logic [20:0]        gain_q;
	logic [15:0]        step_q;
	logic [3:0]         used_q;
	logic               wr;
	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	logic               clearing;
	job_t               push_job;
	job_t               head;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 32'sd0;
			gain_q      <= 21'd65536;
			step_q      <= 16'd6554;
			used_q      <= 4'd1;
		end else if (wr) begin
			case (paddr[3:2])
				REG_THRESHOLD:    threshold_q <= pwdata;
				REG_GAIN:         gain_q      <= pwdata[20:0];
				REG_STEP_RATIO:   step_q      <= pwdata[15:0];
				REG_HISTORY_USED: used_q      <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD:    prdata = threshold_q;
			REG_GAIN:         prdata = {11'd0, gain_q};
			REG_STEP_RATIO:   prdata = {16'd0, step_q};
			REG_HISTORY_USED: prdata = {28'd0, used_q};
			default:          prdata = 32'd0;
		endcase
	end

	rnlu_front #(.NEURONS(NEURONS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.history_used (used_q),
		.q_full       (q_full),
		.clearing     (clearing),
		.busy         (busy),
		.push         (push),
		.push_job     (push_job)
	);

	rnlu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	rnlu_back #(.NEURONS(NEURONS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (q_empty),
		.pop        (pop),
		.threshold  (threshold_q),
		.gain       (gain_q),
		.step_ratio (step_q),
		.clearing   (clearing),
		.done       (done),
		.result     (result)
	);
endmodule
`default_nettype wire

### sim/tb_rate_neuron_leaky_update_top.sv
// ----------------------------------------------------------------------------
// tb_rate_neuron_leaky_update_top
// Self-checking bench for the rate neuron update block. Items are sent
// through the start/busy handshake, and the configuration is written over
// the APB port while the block is idle. A local predictor keeps its own
// sigmoid samples, rate history and ring index. Each done strobe is checked
// against the oldest predicted rate.
// ----------------------------------------------------------------------------
module tb_rate_neuron_leaky_update_top;
	import rnlu_pkg::*;

	localparam int N_NEURONS   = 256;
	localparam int DEPTH       = 8;
	localparam int LUT_N       = 256;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN       = 16;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	in_item_t          cmd = '0;
	logic              done;
	out_item_t         result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	logic signed [31:0] cfg_threshold;
	logic [20:0]        cfg_gain;
	logic [15:0]        cfg_step;
	logic [3:0]         cfg_used;
	logic [2:0]         ring_col;
	logic [15:0]        rate_ring [N_NEURONS][DEPTH];
	logic [15:0]        sig_lut [LUT_N];
	out_item_t          rate_expect_q [$];
	int                 fail_count = 0;
	int                 cycle_count = 0;
	bit                 idle_on = 1'b1;

	rate_neuron_leaky_update_top #(.NEURONS(N_NEURONS), .HISTORY_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(cmd),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [15:0] logistic_point(int k);
		longint unsigned last, mag, z, ip, f, term, e, den, s;
		longint num, sum;
		last = LUT_N - 1;
		num  = 8 * longint'(k) - 4 * longint'(last);
		mag  = (num < 0) ? -num : num;
		z    = (mag << 33) / last;
		ip   = z >> 32;
		f    = z & 64'hFFFF_FFFF;
		term = 64'd1 << 32;
		sum  = term;
		for (int n = 1; n <= 16; n++) begin
			term = ((term * f) >> 32) / n;
			sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
		end
		e = (sum < 0) ? 0 : sum;
		for (longint unsigned n = 0; n < ip; n++) e = (e * 64'd1580030169) >> 32;
		den = (64'd1 << 32) + e;
		s   = ((64'd1 << 47) + den / 2) / den;
		if (num < 0) s = 32768 - s;
		return s[15:0];
	endfunction

	function automatic int ring_span();
		int u;
		u = cfg_used;
		if (u == 0) u = 1;
		if (u > DEPTH) u = DEPTH;
		return u;
	endfunction

	function automatic longint sigmoid_of(longint y);
		longint p, i, f, t0, t1;
		if (y < -SPAN_Q16) y = -SPAN_Q16;
		if (y > SPAN_Q16) y = SPAN_Q16;
		p  = (y + SPAN_Q16) * (LUT_N - 1);
		i  = p / 524288;
		f  = p % 524288;
		t0 = sig_lut[i];
		if (f == 0 || i >= LUT_N - 1) return t0;
		t1 = sig_lut[i + 1];
		return t0 + (((t1 - t0) * f + 262144) >>> 19);
	endfunction

	// advance the local neuron state for one accepted item
	task automatic predict_rate(in_item_t it);
		int used, cur, col;
		longint y, s, r, nr;
		out_item_t exp_r;
		used = ring_span();
		cur  = ring_col % used;
		if (it.opcode == OP_COMMIT) begin
			ring_col = 3'((cur + 1) % used);
		end else if (it.opcode == OP_READ) begin
			col = (cur + used - (it.delay % used)) % used;
			exp_r.rate = rate_ring[it.neuron][col];
			exp_r.neuron_out = it.neuron;
			rate_expect_q = {rate_expect_q, exp_r};
		end else if (it.opcode == OP_UPDATE) begin
			y  = (longint'(cfg_gain) * (longint'(it.activation) - longint'(cfg_threshold))) >>> 16;
			s  = sigmoid_of(y);
			r  = rate_ring[it.neuron][cur];
			nr = r + ((longint'(cfg_step) * (s - r) + 32768) >>> 16);
			if (nr < 0) nr = 0;
			if (nr > ONE_Q15) nr = ONE_Q15;
			rate_ring[it.neuron][(cur + 1) % used] = nr[15:0];
			exp_r.rate = nr[15:0];
			exp_r.neuron_out = it.neuron;
			rate_expect_q = {rate_expect_q, exp_r};
		end
	endtask

	always @(negedge clk) begin
		out_item_t exp_r;
		if (arst_n && done) begin
			if (rate_expect_q.size() == 0) begin
				$display("%0t: result expected none actual rate=%0d neuron=%0d", $time,
					result.rate, result.neuron_out);
				fail_count++;
			end else begin
				exp_r = rate_expect_q.pop_front();
				if (result.rate !== exp_r.rate) begin
					$display("%0t: rate expected %0d actual %0d", $time, exp_r.rate,
						result.rate);
					fail_count++;
				end
				if (result.neuron_out !== exp_r.neuron_out) begin
					$display("%0t: neuron expected %0d actual %0d", $time,
						exp_r.neuron_out, result.neuron_out);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(in_item_t it);
		cmd <= it;
		start <= 1'b1;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		predict_rate(it);
	endtask

	task automatic pause_input();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (rate_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_THRESHOLD:    cfg_threshold = value;
			REG_GAIN:         cfg_gain = value[20:0];
			REG_STEP_RATIO:   cfg_step = value[15:0];
			REG_HISTORY_USED: cfg_used = value[3:0];
		endcase
	endtask

	function automatic in_item_t make_item(logic [1:0] op, logic [7:0] n,
			logic [31:0] act, logic [2:0] d);
		in_item_t it;
		it.opcode = op;
		it.neuron = n;
		it.activation = act;
		it.delay = d;
		return it;
	endfunction

	function automatic logic [31:0] pick_activation();
		case ($urandom_range(0, 5))
			0:       return $urandom();
			1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return cfg_threshold + 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	function automatic in_item_t random_item();
		logic [1:0] op;
		int sel;
		sel = $urandom_range(0, 99);
		op = (sel < 58) ? OP_UPDATE : (sel < 83) ? OP_READ : (sel < 97) ? OP_COMMIT : OP_SPARE;
		return make_item(op, (sel % 2) ? 8'($urandom_range(0, 7)) : 8'($urandom()),
			pick_activation(), 3'($urandom()));
	endfunction

	task automatic test_directed();
		send_item(make_item(OP_UPDATE, 8'd0, 32'h7FFF_FFFF, 3'd0));
		send_item(make_item(OP_UPDATE, 8'd0, 32'h7FFF_FFFF, 3'd7));
		send_item(make_item(OP_UPDATE, 8'd255, 32'h8000_0000, 3'd0));
		send_item(make_item(OP_UPDATE, 8'd1, 32'h0, 3'd0));
		send_item(make_item(OP_READ, 8'd0, 32'hFFFF_FFFF, 3'd7));
		send_item(make_item(OP_COMMIT, 8'd0, 32'h0, 3'd0));
		send_item(make_item(OP_SPARE, 8'd0, 32'h1234_5678, 3'd5));
		send_item(make_item(OP_READ, 8'd255, 32'h0, 3'd0));
		wait_quiet();
		write_reg(REG_HISTORY_USED, 32'd8);
		write_reg(REG_STEP_RATIO, 32'd65535);
		write_reg(REG_GAIN, 32'd1048576);
		write_reg(REG_THRESHOLD, 32'h8000_0000);
		send_item(make_item(OP_UPDATE, 8'd2, 32'h7FFF_FFFF, 3'd0));
		send_item(make_item(OP_COMMIT, 8'd0, 32'h0, 3'd0));
		send_item(make_item(OP_UPDATE, 8'd2, 32'h0001_8000, 3'd0));
		send_item(make_item(OP_READ, 8'd2, 32'h0, 3'd1));
		send_item(make_item(OP_READ, 8'd2, 32'h0, 3'd7));
		wait_quiet();
		write_reg(REG_THRESHOLD, 32'h7FFF_FFFF);
		write_reg(REG_GAIN, 32'd0);
		write_reg(REG_STEP_RATIO, 32'd0);
		write_reg(REG_HISTORY_USED, 32'd0);
		send_item(make_item(OP_UPDATE, 8'd3, 32'h8000_0000, 3'd0));
		send_item(make_item(OP_READ, 8'd3, 32'h0, 3'd3));
		wait_quiet();
		write_reg(REG_HISTORY_USED, 32'd15);
		write_reg(REG_GAIN, 32'd65536);
		write_reg(REG_STEP_RATIO, 32'd40000);
		write_reg(REG_THRESHOLD, 32'h0);
		send_item(make_item(OP_UPDATE, 8'd4, 32'hFFFC_0000, 3'd0));
		send_item(make_item(OP_UPDATE, 8'd4, 32'h0004_0000, 3'd0));
		send_item(make_item(OP_READ, 8'd4, 32'h0, 3'd6));
		wait_quiet();
	endtask

	task automatic test_random_phase(int count, logic [31:0] thr, logic [31:0] g,
			logic [31:0] st, logic [31:0] used);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_GAIN, g);
		write_reg(REG_STEP_RATIO, st);
		write_reg(REG_HISTORY_USED, used);
		for (int k = 0; k < count; k++) begin
			pause_input();
			send_item(random_item());
		end
		wait_quiet();
	endtask

	initial begin
		cfg_threshold = 0;
		cfg_gain = 21'd65536;
		cfg_step = 16'd6554;
		cfg_used = 4'd1;
		ring_col = '0;
		foreach (rate_ring[n, c]) rate_ring[n][c] = '0;
		for (int k = 0; k < LUT_N; k++) sig_lut[k] = logistic_point(k);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(220, 32'h0, 32'd65536, 32'd6554, 32'd1);
		test_random_phase(220, 32'($urandom()), 32'($urandom_range(0, 1048576)),
			32'($urandom_range(0, 65535)), 32'd8);
		test_random_phase(220, 32'hFFFF_0000, 32'd1048576, 32'd65535, 32'd3);
		test_random_phase(220, 32'h0002_0000, 32'd16384, 32'd1, 32'd12);
		test_random_phase(220, 32'($urandom()), 32'($urandom_range(0, 200000)),
			32'($urandom_range(20000, 65535)), 32'($urandom_range(0, 15)));
		idle_on = 1'b0;
		test_random_phase(200, 32'h0, 32'd131072, 32'd30000, 32'd5);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
